@@ design/crpt_pkg.sv @@
// Shared types, widths and codes for the Catmull-Rom point table.
package crpt_pkg;

  // Field and datapath widths.
  localparam int COORD_W = 32;
  localparam int LEN_W   = 42;
  localparam int FRAC_W  = 17;
  localparam int D_W     = 33;   // distance, Q17.16 magnitude
  localparam int T_W     = 36;   // signed knot time
  localparam int V_W     = 48;   // pyramid value, clamped to 48 bits
  localparam int MA_W    = 48;   // multiplier operand A
  localparam int MB_W    = 36;   // multiplier operand B
  localparam int PP_W    = 42;   // one 24 x 18 partial product
  localparam int NUM_W   = 84;   // signed blend numerator
  localparam int MAG_W   = 83;   // numerator magnitude
  localparam int DV_W    = 35;   // divisor and division remainder
  localparam int SQ_W    = 66;   // sum of squares
  localparam int SR_W    = 35;   // square root remainder

  localparam logic [LEN_W-1:0] LEN_MAX = '1;

  // Command codes.
  localparam logic [1:0] CMD_APPEND    = 2'd0;
  localparam logic [1:0] CMD_OVERWRITE = 2'd1;
  localparam logic [1:0] CMD_EVAL      = 2'd2;

  // Status codes.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;
  localparam logic [1:0] ST_ZERO  = 2'd3;

  // Sequencer states.
  typedef enum logic [4:0] {
    S_IDLE,
    S_DECODE,
    S_WALK_INIT,
    S_WALK_CAP0,
    S_WALK_RD,
    S_WALK_CAP,
    S_WALK_ACC,
    S_LOAD,
    S_EVD0,
    S_EVD1,
    S_EVD2,
    S_EVD3,
    S_EVT,
    S_BL0,
    S_BL1,
    S_BL2,
    S_DIV,
    S_BL3,
    S_AXIS,
    S_DIST,
    S_SQ,
    S_SQ_ACC,
    S_SQRT,
    S_MUL,
    S_REPORT
  } state_t;

  // Saturate a pyramid value to a 32-bit coordinate.
  function automatic logic signed [COORD_W-1:0] sat32(input logic signed [V_W-1:0] v);
    logic signed [V_W-1:0] hi;
    logic signed [V_W-1:0] lo;
    hi = V_W'(32'sh7FFF_FFFF);
    lo = -V_W'(48'sh0000_8000_0000);
    if (v > hi) begin
      sat32 = 32'sh7FFF_FFFF;
    end else if (v < lo) begin
      sat32 = 32'sh8000_0000;
    end else begin
      sat32 = v[COORD_W-1:0];
    end
  endfunction

endpackage

@@ design/catmull_rom_point_table_top.sv @@
// Top level of the chordal Catmull-Rom point table.
//
// A request is taken when start is high and busy is low; exactly one result
// follows, shown for one cycle with done high, and it cannot be held off.
// All arithmetic runs through one sequencer around a 24 x 18 multiplier
// (four partial products), a one-bit-per-cycle divider and a
// two-bit-per-cycle square root. A rejected request or an unused command
// goes from decode straight to the report. An accepted append or overwrite
// rewrites the table and then, with more than three points, walks the
// segments from point 1 to point count - 2 once to rebuild the length, one
// distance (three squares and a root) per segment. An evaluation computes
// three distances and eighteen pyramid blends, each blend dominated by its
// division; a zero distance ends it early with a zero status.
module catmull_rom_point_table_top #(
  parameter int MAX_POINTS = 256
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [1:0]                           cmd,
  input  logic [7:0]                           index,
  input  logic signed [crpt_pkg::COORD_W-1:0]  coord_x,
  input  logic signed [crpt_pkg::COORD_W-1:0]  coord_y,
  input  logic signed [crpt_pkg::COORD_W-1:0]  coord_z,
  input  logic [crpt_pkg::FRAC_W-1:0]          fraction,
  output logic                                 done,
  output logic signed [crpt_pkg::COORD_W-1:0]  out_x,
  output logic signed [crpt_pkg::COORD_W-1:0]  out_y,
  output logic signed [crpt_pkg::COORD_W-1:0]  out_z,
  output logic [crpt_pkg::LEN_W-1:0]           path_length,
  output logic [7:0]                           points_held,
  output logic [1:0]                           status
);

  import crpt_pkg::*;

  localparam int AW = $clog2(MAX_POINTS);
  localparam int XW = ((AW > 8) ? AW : 8) + 2;
  localparam int PW = 3 * COORD_W;

  // Sequencer and request registers.
  state_t state, state_next, mul_ret, dist_ret;
  logic [1:0]        cmd_r;
  logic [7:0]        idx_r;
  logic [FRAC_W-1:0] frac_r;
  logic [PW-1:0]     wdata_r;
  logic [1:0]        st;

  // Table bookkeeping.
  logic [AW-1:0]    count;
  logic [LEN_W-1:0] len_sum;
  logic [LEN_W-1:0] wsum;
  logic [AW-1:0]    wi;

  // Points and distance operands.
  logic signed [COORD_W-1:0] pt [4][3];
  logic signed [COORD_W-1:0] ua [3];
  logic signed [COORD_W-1:0] ub [3];
  logic [2:0] lcnt;
  logic [1:0] dk;

  // Square root unit.
  logic [SQ_W-1:0] dsum;
  logic [SQ_W-1:0] rad;
  logic [SR_W-1:0] srem;
  logic [D_W-1:0]  root;
  logic [5:0]      scnt;

  // Knots and pyramid values.
  logic [D_W-1:0]        d01, d12;
  logic signed [T_W-1:0] t1, t2, t3, tv;
  logic [2:0]            bs;
  logic [1:0]            ax;
  logic signed [V_W-1:0] a1, a2, a3, b1, b2, cval;
  logic signed [COORD_W-1:0] res [3];

  // Multiplier unit.
  logic [MA_W-1:0]  ma;
  logic [MB_W-1:0]  mb;
  logic [PP_W-1:0]  pp;
  logic [1:0]       ppsel;
  logic [2:0]       mcnt;
  logic [NUM_W-1:0] acc;
  logic             psign;

  // Divider unit.
  logic signed [NUM_W-1:0] numer;
  logic                    dneg;
  logic [MAG_W-1:0]        dnum;
  logic [DV_W-1:0]         dvs;
  logic [DV_W-1:0]         drem;
  logic [V_W-1:0]          quo;
  logic                    qovf;
  logic [6:0]              dcnt;

  // Memory port.
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [AW-1:0] ram_raddr;
  logic [PW-1:0] ram_rdata;

  crpt_ram #(
    .WIDTH (PW),
    .DEPTH (MAX_POINTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (wdata_r),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Range checks on the request.
  logic [XW-1:0] idx_x, cnt_x;
  logic full, ov_bad, ev_bad, write_ok, walk_more;
  assign idx_x     = XW'(idx_r);
  assign cnt_x     = XW'(count);
  assign full      = cnt_x >= XW'(MAX_POINTS - 1);
  assign ov_bad    = idx_x >= cnt_x;
  assign ev_bad    = (idx_x == '0) || (idx_x + XW'(2) >= cnt_x);
  assign write_ok  = ((cmd_r == CMD_APPEND) && !full) ||
                     ((cmd_r == CMD_OVERWRITE) && !ov_bad);
  assign walk_more = XW'(wi) + XW'(3) < cnt_x;

  // Blend operand selection by pyramid step.
  logic signed [V_W-1:0] bp, bq;
  logic signed [T_W-1:0] bta, btb, f1, f2;
  always_comb begin
    case (bs)
      3'd0: begin
        bp = V_W'(pt[0][0]); bq = V_W'(pt[1][0]); bta = '0; btb = t1;
      end
      3'd1: begin
        bp = V_W'(pt[1][0]); bq = V_W'(pt[2][0]); bta = t1; btb = t2;
      end
      3'd2: begin
        bp = V_W'(pt[2][0]); bq = V_W'(pt[3][0]); bta = t2; btb = t3;
      end
      3'd3: begin
        bp = a1; bq = a2; bta = '0; btb = t2;
      end
      3'd4: begin
        bp = a2; bq = a3; bta = t1; btb = t3;
      end
      default: begin
        bp = b1; bq = b2; bta = t1; btb = t2;
      end
    endcase
  end
  assign f1 = btb - tv;
  assign f2 = tv - bta;

  // Magnitudes for the multiplier.
  logic [V_W-1:0] bp_mag, bq_mag;
  logic [T_W-1:0] f1_mag, f2_mag;
  assign bp_mag = bp[V_W-1] ? V_W'(-bp) : V_W'(bp);
  assign bq_mag = bq[V_W-1] ? V_W'(-bq) : V_W'(bq);
  assign f1_mag = f1[T_W-1] ? T_W'(-f1) : T_W'(f1);
  assign f2_mag = f2[T_W-1] ? T_W'(-f2) : T_W'(f2);

  // Coordinate difference for one squared term.
  logic signed [D_W-1:0] diff;
  logic [D_W-1:0]        diff_mag;
  assign diff     = D_W'(ub[0]) - D_W'(ua[0]);
  assign diff_mag = diff[D_W-1] ? D_W'(-diff) : D_W'(diff);

  // Partial product selection and alignment.
  logic [23:0]      a_ch;
  logic [17:0]      b_ch;
  logic [NUM_W-1:0] pp_al;
  assign a_ch = mcnt[0] ? ma[47:24] : ma[23:0];
  assign b_ch = mcnt[1] ? mb[35:18] : mb[17:0];
  always_comb begin
    case (ppsel)
      2'd0:    pp_al = NUM_W'(pp);
      2'd1:    pp_al = NUM_W'(pp) << 24;
      2'd2:    pp_al = NUM_W'(pp) << 18;
      default: pp_al = NUM_W'(pp) << 42;
    endcase
  end

  // Numerator sum of the two signed products.
  logic signed [NUM_W-1:0] nsum, nmag;
  assign nsum = numer + (psign ? -$signed(acc) : $signed(acc));
  assign nmag = nsum[NUM_W-1] ? -nsum : nsum;

  // One restoring division step.
  logic [DV_W:0] dr2;
  logic          dge;
  assign dr2 = {drem, dnum[MAG_W-1]};
  assign dge = dr2 >= {1'b0, dvs};

  // Quotient clamp and sign.
  logic [V_W-1:0]        cap, qv;
  logic signed [V_W-1:0] bres;
  assign cap  = dneg ? {1'b1, {(V_W-1){1'b0}}} : {1'b0, {(V_W-1){1'b1}}};
  assign qv   = (qovf || (quo > cap)) ? cap : quo;
  assign bres = dneg ? -$signed(qv) : $signed(qv);

  // One square root step.
  logic [SR_W+1:0] sr2, strial;
  logic            sge;
  assign sr2    = {srem, rad[SQ_W-1 -: 2]};
  assign strial = (SR_W+2)'({root, 2'b01});
  assign sge    = sr2 >= strial;

  // Saturating length accumulation.
  logic [LEN_W:0]   wadd;
  logic [LEN_W-1:0] wsat;
  assign wadd = {1'b0, wsum} + (LEN_W+1)'(root);
  assign wsat = wadd[LEN_W] ? LEN_MAX : wadd[LEN_W-1:0];

  // Clamped fraction and knot sums.
  logic [FRAC_W-1:0] frac_c;
  logic signed [T_W-1:0] t2_sum;
  assign frac_c = (frac_r > FRAC_W'(65536)) ? FRAC_W'(65536) : frac_r;
  assign t2_sum = T_W'(d01) + T_W'(d12);

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:      if (start) state_next = S_DECODE;
      S_DECODE: begin
        case (cmd_r)
          CMD_APPEND:    state_next = full ? S_REPORT : S_WALK_INIT;
          CMD_OVERWRITE: state_next = ov_bad ? S_REPORT : S_WALK_INIT;
          CMD_EVAL:      state_next = ev_bad ? S_REPORT : S_LOAD;
          default:       state_next = S_REPORT;
        endcase
      end
      S_WALK_INIT: state_next = (cnt_x > XW'(3)) ? S_WALK_CAP0 : S_REPORT;
      S_WALK_CAP0: state_next = S_WALK_RD;
      S_WALK_RD:   state_next = S_WALK_CAP;
      S_WALK_CAP:  state_next = S_DIST;
      S_WALK_ACC:  state_next = walk_more ? S_WALK_RD : S_REPORT;
      S_LOAD:      if (lcnt == 3'd4) state_next = S_EVD0;
      S_EVD0:      state_next = S_DIST;
      S_EVD1:      state_next = S_DIST;
      S_EVD2:      state_next = S_DIST;
      S_EVD3: begin
        if ((d01 == '0) || (d12 == '0) || (root == '0)) begin
          state_next = S_REPORT;
        end else begin
          state_next = S_MUL;
        end
      end
      S_EVT:       state_next = S_BL0;
      S_BL0:       state_next = S_MUL;
      S_BL1:       state_next = S_MUL;
      S_BL2:       state_next = S_DIV;
      S_DIV:       if (dcnt == 7'(MAG_W - 1)) state_next = S_BL3;
      S_BL3:       state_next = (bs == 3'd5) ? S_AXIS : S_BL0;
      S_AXIS:      state_next = (ax == 2'd2) ? S_REPORT : S_BL0;
      S_DIST:      state_next = S_SQ;
      S_SQ:        state_next = S_MUL;
      S_SQ_ACC:    state_next = (dk == 2'd2) ? S_SQRT : S_SQ;
      S_SQRT:      if (scnt == 6'(D_W - 1)) state_next = dist_ret;
      S_MUL:       if (mcnt == 3'd4) state_next = mul_ret;
      S_REPORT:    state_next = S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  // Memory control and handshake outputs.
  always_comb begin
    busy      = state != S_IDLE;
    ram_we    = (state == S_DECODE) && write_ok;
    ram_waddr = (cmd_r == CMD_APPEND) ? count : AW'(idx_r);
    case (state)
      S_WALK_INIT: ram_raddr = AW'(1);
      S_WALK_RD:   ram_raddr = wi + AW'(1);
      S_LOAD:      ram_raddr = AW'(idx_x - XW'(1) + XW'(lcnt));
      default:     ram_raddr = '0;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      count   <= '0;
      len_sum <= '0;
      done    <= 1'b0;
    end else begin
      state <= state_next;
      done  <= state == S_REPORT;
      if ((state == S_DECODE) && (cmd_r == CMD_APPEND) && !full) begin
        count <= count + AW'(1);
      end
      if ((state == S_WALK_INIT) && !(cnt_x > XW'(3))) begin
        len_sum <= '0;
      end
      if ((state == S_WALK_ACC) && !walk_more) begin
        len_sum <= wsat;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd_r   <= cmd;
          idx_r   <= index;
          frac_r  <= fraction;
          wdata_r <= {coord_z, coord_y, coord_x};
        end
      end
      S_DECODE: begin
        res[0] <= '0;
        res[1] <= '0;
        res[2] <= '0;
        lcnt   <= '0;
        case (cmd_r)
          CMD_APPEND:    st <= full ? ST_FULL : ST_OK;
          CMD_OVERWRITE: st <= ov_bad ? ST_RANGE : ST_OK;
          CMD_EVAL:      st <= ev_bad ? ST_RANGE : ST_OK;
          default:       st <= ST_OK;
        endcase
      end
      S_WALK_INIT: begin
        wsum <= '0;
        wi   <= AW'(1);
      end
      S_WALK_CAP0: begin
        ub[0] <= ram_rdata[31:0];
        ub[1] <= ram_rdata[63:32];
        ub[2] <= ram_rdata[95:64];
      end
      S_WALK_RD: begin
        ua <= ub;
      end
      S_WALK_CAP: begin
        ub[0]    <= ram_rdata[31:0];
        ub[1]    <= ram_rdata[63:32];
        ub[2]    <= ram_rdata[95:64];
        dist_ret <= S_WALK_ACC;
      end
      S_WALK_ACC: begin
        wsum <= wsat;
        wi   <= wi + AW'(1);
      end
      S_LOAD: begin
        lcnt <= lcnt + 3'd1;
        if (lcnt != 3'd0) begin
          pt[0] <= pt[1];
          pt[1] <= pt[2];
          pt[2] <= pt[3];
          pt[3][0] <= ram_rdata[31:0];
          pt[3][1] <= ram_rdata[63:32];
          pt[3][2] <= ram_rdata[95:64];
        end
      end
      S_EVD0: begin
        ua       <= pt[0];
        ub       <= pt[1];
        dist_ret <= S_EVD1;
      end
      S_EVD1: begin
        d01      <= root;
        ua       <= pt[1];
        ub       <= pt[2];
        dist_ret <= S_EVD2;
      end
      S_EVD2: begin
        d12      <= root;
        ua       <= pt[2];
        ub       <= pt[3];
        dist_ret <= S_EVD3;
      end
      S_EVD3: begin
        if ((d01 == '0) || (d12 == '0) || (root == '0)) begin
          st <= ST_ZERO;
        end
        t1      <= T_W'(d01);
        t2      <= t2_sum;
        t3      <= t2_sum + T_W'(root);
        ma      <= MA_W'(d12);
        mb      <= MB_W'(frac_c);
        mcnt    <= '0;
        acc     <= '0;
        mul_ret <= S_EVT;
      end
      S_EVT: begin
        tv <= t1 + T_W'(acc[49:16]);
        bs <= '0;
        ax <= '0;
      end
      S_BL0: begin
        ma      <= bp_mag;
        mb      <= MB_W'(f1_mag);
        psign   <= bp[V_W-1] ^ f1[T_W-1];
        mcnt    <= '0;
        acc     <= '0;
        mul_ret <= S_BL1;
      end
      S_BL1: begin
        numer   <= psign ? -$signed(acc) : $signed(acc);
        ma      <= bq_mag;
        mb      <= MB_W'(f2_mag);
        psign   <= bq[V_W-1] ^ f2[T_W-1];
        mcnt    <= '0;
        acc     <= '0;
        mul_ret <= S_BL2;
      end
      S_BL2: begin
        dneg <= nsum[NUM_W-1];
        dnum <= nmag[MAG_W-1:0];
        dvs  <= DV_W'(btb - bta);
        drem <= '0;
        quo  <= '0;
        qovf <= 1'b0;
        dcnt <= '0;
      end
      S_DIV: begin
        drem <= dge ? DV_W'(dr2 - {1'b0, dvs}) : dr2[DV_W-1:0];
        quo  <= {quo[V_W-2:0], dge};
        qovf <= qovf | quo[V_W-1];
        dnum <= dnum << 1;
        dcnt <= dcnt + 7'd1;
      end
      S_BL3: begin
        case (bs)
          3'd0:    a1 <= bres;
          3'd1:    a2 <= bres;
          3'd2:    a3 <= bres;
          3'd3:    b1 <= bres;
          3'd4:    b2 <= bres;
          default: cval <= bres;
        endcase
        bs <= bs + 3'd1;
      end
      S_AXIS: begin
        res[0] <= res[1];
        res[1] <= res[2];
        res[2] <= sat32(cval);
        for (int j = 0; j < 4; j++) begin
          pt[j][0] <= pt[j][1];
          pt[j][1] <= pt[j][2];
          pt[j][2] <= pt[j][0];
        end
        bs <= '0;
        ax <= ax + 2'd1;
      end
      S_DIST: begin
        dsum <= '0;
        dk   <= '0;
      end
      S_SQ: begin
        ma      <= MA_W'(diff_mag);
        mb      <= MB_W'(diff_mag);
        mcnt    <= '0;
        acc     <= '0;
        mul_ret <= S_SQ_ACC;
      end
      S_SQ_ACC: begin
        dsum  <= dsum + acc[SQ_W-1:0];
        rad   <= dsum + acc[SQ_W-1:0];
        srem  <= '0;
        root  <= '0;
        scnt  <= '0;
        ua[0] <= ua[1];
        ua[1] <= ua[2];
        ua[2] <= ua[0];
        ub[0] <= ub[1];
        ub[1] <= ub[2];
        ub[2] <= ub[0];
        dk    <= dk + 2'd1;
      end
      S_SQRT: begin
        srem <= sge ? SR_W'(sr2 - strial) : SR_W'(sr2);
        root <= {root[D_W-2:0], sge};
        rad  <= rad << 2;
        scnt <= scnt + 6'd1;
      end
      S_MUL: begin
        if (mcnt != 3'd4) begin
          pp    <= a_ch * b_ch;
          ppsel <= mcnt[1:0];
        end
        if (mcnt != 3'd0) begin
          acc <= acc + pp_al;
        end
        mcnt <= mcnt + 3'd1;
      end
      S_REPORT: begin
        out_x       <= res[0];
        out_y       <= res[1];
        out_z       <= res[2];
        path_length <= len_sum;
        points_held <= cnt_x[7:0];
        status      <= st;
      end
      default: begin
      end
    endcase
  end

  // A result only follows the report step.
  a_done_src: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(state) == S_REPORT))
    else $error("result strobe without a report step");

  // An accepted request always starts decoding.
  a_accept: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (state == S_DECODE))
    else $error("accepted request did not enter decode");

  // A flagged result carries a zero point.
  a_flag_zero: assert property (@(posedge clk) disable iff (rst)
    (done && (status != ST_OK)) |-> ((out_x == '0) && (out_y == '0) && (out_z == '0)))
    else $error("flagged result with nonzero point");

  // The divider never runs with a zero knot interval.
  a_div_nz: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (dvs != '0))
    else $error("division by a zero knot interval");

endmodule

@@ design/crpt_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module crpt_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
